### src/msa_pkg.sv
// Shared constants and item codes for the multichannel sample averager.
package msa_pkg;

	// Default geometry
	localparam int CHANNELS_DEF   = 8;
	localparam int COUNT_BITS_DEF = 8;

	// Converter word handling
	localparam int RAW_BITS     = 16;
	localparam int SAMPLE_SHIFT = 3;
	localparam int SAMPLE_BITS  = RAW_BITS - SAMPLE_SHIFT;

	// Port field widths
	localparam int KIND_BITS    = 2;
	localparam int CHAN_BITS    = 3;
	localparam int S_DATA_BITS  = 24;
	localparam int M_DATA_BITS  = 16;

	// Item kinds
	localparam logic [KIND_BITS-1:0] KIND_SAMPLE = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_READ   = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd2;

endpackage

### src/multichannel_sample_averager_unit.sv
// Top level of the multichannel sample averager: channel memory, divider and stream ports.
//
// Each channel keeps a running sum of converter words (shifted right by 3) and a
// saturating sample count in one synchronous memory. Items are taken one at a time.
// A sample beat runs a memory read, then a modify and write back. A read beat runs
// the memory read and divider setup, one quotient bit per cycle from a restoring
// divider over the 13 + COUNT_BITS sum bits, and the load of the output register. A
// read that finds a result still waiting holds in the last step until m_tready takes
// it. An empty or out-of-range read skips the divider. A clear beat and an unknown
// kind leave the block idle; clear drops every channel at once through per-entry
// valid bits, so no clearing pass runs after reset. The result register lets the
// next beat in while a result waits for m_tready.
module multichannel_sample_averager_unit #(
	parameter int CHANNELS   = msa_pkg::CHANNELS_DEF,
	parameter int COUNT_BITS = msa_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [msa_pkg::S_DATA_BITS-1:0]  s_tdata,  // channel[2:0], raw_word[18:3], zero
	input  logic [msa_pkg::KIND_BITS-1:0]    s_tuser,  // kind[1:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [msa_pkg::M_DATA_BITS-1:0]  m_tdata,  // average[12:0], zero
	output logic                             m_tuser   // was_empty
);

	localparam int SUM_BITS = msa_pkg::SAMPLE_BITS + COUNT_BITS;
	localparam int ENT_BITS = SUM_BITS + COUNT_BITS;
	localparam int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW       = $clog2(SUM_BITS);
	localparam int CB       = msa_pkg::CHAN_BITS;

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MOD  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_OUT  = 3'd3;

	logic [2:0]                          state_q;
	logic [msa_pkg::KIND_BITS-1:0]       kind_q;
	logic [AW-1:0]                       addr_q;
	logic                                range_q;
	logic [msa_pkg::SAMPLE_BITS-1:0]     word_q;

	logic [ENT_BITS-1:0]                 mem [CHANNELS];
	logic [ENT_BITS-1:0]                 ent_s1;
	logic                                vld_s1;
	logic [CHANNELS-1:0]                 vld_q;

	logic [COUNT_BITS-1:0]               rem_q;
	logic [SUM_BITS-1:0]                 quo_q;
	logic [COUNT_BITS-1:0]               dvs_q;
	logic [SW-1:0]                       step_q;
	logic                                empty_q;

	logic                                m_valid_q;
	logic [msa_pkg::SAMPLE_BITS-1:0]     avg_q;
	logic                                was_empty_q;

	logic [msa_pkg::KIND_BITS-1:0]       in_kind;
	logic [CB-1:0]                       in_chan;
	logic [msa_pkg::RAW_BITS-1:0]        in_word;
	logic [AW+CB-1:0]                    chan_ext;
	logic [AW-1:0]                       in_addr;
	logic                                in_range;
	logic                                accept;
	logic                                rd_en;

	logic [SUM_BITS-1:0]                 cur_sum;
	logic [COUNT_BITS-1:0]               cur_cnt;
	logic                                wr_en;
	logic [ENT_BITS-1:0]                 wr_data;

	logic [COUNT_BITS:0]                 rem_sh;
	logic [COUNT_BITS:0]                 rem_diff;
	logic                                rem_ge;
	logic                                out_free;

	// Unpack the input beat
	assign in_kind  = s_tuser;
	assign in_chan  = s_tdata[CB-1:0];
	assign in_word  = s_tdata[CB+msa_pkg::RAW_BITS-1:CB];
	assign chan_ext = {{AW{1'b0}}, in_chan};
	assign in_addr  = chan_ext[AW-1:0];
	assign in_range = (32'(in_chan) < CHANNELS);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign rd_en    = accept && ((in_kind == msa_pkg::KIND_SAMPLE) ||
		(in_kind == msa_pkg::KIND_READ));

	// Entry seen by the modify step; an entry not valid reads as zero
	assign cur_sum = vld_s1 ? ent_s1[ENT_BITS-1:COUNT_BITS] : '0;
	assign cur_cnt = vld_s1 ? ent_s1[COUNT_BITS-1:0] : '0;

	assign wr_en   = (state_q == S_MOD) && (kind_q == msa_pkg::KIND_SAMPLE) &&
		range_q && (cur_cnt != '1);
	assign wr_data = {cur_sum + SUM_BITS'(word_q), cur_cnt + COUNT_BITS'(1)};

	// One restoring division step
	assign rem_sh   = {rem_q, quo_q[SUM_BITS-1]};
	assign rem_diff = rem_sh - {1'b0, dvs_q};
	assign rem_ge   = (rem_sh >= {1'b0, dvs_q});

	assign out_free = !m_valid_q || m_tready;

	// Channel memory: write back the modified entry, read on accept
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_q] <= wr_data;
		end
		if (rd_en) begin
			ent_s1 <= mem[in_addr];
		end
	end

	// Sequencer and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_kind == msa_pkg::KIND_CLEAR) begin
							vld_q <= '0;
						end else if (rd_en) begin
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (kind_q == msa_pkg::KIND_SAMPLE) begin
						if (wr_en) begin
							vld_q[addr_q] <= 1'b1;
						end
						state_q <= S_IDLE;
					end else begin
						if (range_q) begin
							vld_q[addr_q] <= 1'b0;
						end
						state_q <= (range_q && cur_cnt != '0) ? S_DIV : S_OUT;
					end
				end
				S_DIV: begin
					if (step_q == '0) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the accepted beat and the valid bit of its entry
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= in_kind;
			addr_q  <= in_addr;
			range_q <= in_range;
			word_q  <= in_word[msa_pkg::RAW_BITS-1:msa_pkg::SAMPLE_SHIFT];
			vld_s1  <= vld_q[in_addr];
		end
	end

	// Divider: load on a read, then shift in one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (state_q == S_MOD) begin
			rem_q   <= '0;
			quo_q   <= range_q ? cur_sum : '0;
			dvs_q   <= cur_cnt;
			step_q  <= SW'(SUM_BITS - 1);
			empty_q <= !range_q || (cur_cnt == '0);
		end else if (state_q == S_DIV) begin
			rem_q  <= rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
			quo_q  <= {quo_q[SUM_BITS-2:0], rem_ge};
			step_q <= step_q - SW'(1);
		end
	end

	// Result register: set on a finished read, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			avg_q       <= empty_q ? '0 : quo_q[msa_pkg::SAMPLE_BITS-1:0];
			was_empty_q <= empty_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(msa_pkg::M_DATA_BITS - msa_pkg::SAMPLE_BITS){1'b0}}, avg_q};
	assign m_tuser  = was_empty_q;

endmodule

### src/msa_checker.sv
// Port-level checks for the multichannel sample averager, bound to the top level.
module msa_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [msa_pkg::S_DATA_BITS-1:0]  s_tdata,
	input logic [msa_pkg::KIND_BITS-1:0]    s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [msa_pkg::M_DATA_BITS-1:0]  m_tdata,
	input logic                             m_tuser
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// An empty channel reads as zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("empty result with nonzero average");

	// The average never exceeds the sample width
	a_avg_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[msa_pkg::M_DATA_BITS-1:msa_pkg::SAMPLE_BITS] == '0)
		else $error("average wider than sample");

	// A sample or read beat occupies the block for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready &&
		(s_tuser == msa_pkg::KIND_SAMPLE || s_tuser == msa_pkg::KIND_READ) |=> !s_tready)
		else $error("input taken while an entry update is in flight");

endmodule

bind multichannel_sample_averager_unit msa_checker u_msa_checker (.*);

### verif/tb_multichannel_sample_averager_unit.sv
// Testbench for the multichannel sample averager: stream driver, monitor and channel predictor.
module tb_multichannel_sample_averager_unit;
	import msa_pkg::*;

	localparam int                   CHAN_COUNT    = CHANNELS_DEF;
	localparam int                   CNT_BITS      = COUNT_BITS_DEF;
	localparam int                   SUM_BITS      = SAMPLE_BITS + CNT_BITS;
	localparam logic [CNT_BITS-1:0]  CNT_MAX       = {CNT_BITS{1'b1}};
	localparam logic [KIND_BITS-1:0] KIND_RESERVED = 2'd3;
	localparam int                   RANDOM_ITEMS  = 800;
	localparam int                   HOLD_AT_BEAT  = 350;
	localparam int                   HOLD_CYCLES   = 600;
	localparam int                   DRAIN_CYCLES  = 60;

	typedef struct {
		logic [KIND_BITS-1:0] kind;
		logic [CHAN_BITS-1:0] channel;
		logic [RAW_BITS-1:0]  raw_word;
		bit                   wait_idle;
	} adc_item_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] average;
		logic                   was_empty;
	} avg_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_DATA_BITS-1:0] s_tdata = '0;  // channel[2:0], raw_word[18:3], zero
	logic [KIND_BITS-1:0]   s_tuser = '0;  // kind[1:0]
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_DATA_BITS-1:0] m_tdata;       // average[12:0], zero
	logic                   m_tuser;       // was_empty

	adc_item_t           pending_items[$];
	avg_result_t         avg_expected[$];
	logic [SUM_BITS-1:0] chan_sum[CHAN_COUNT];
	logic [CNT_BITS-1:0] chan_count[CHAN_COUNT];

	int        total_items = 0;
	int        beats_in = 0;
	int        results_out = 0;
	int        error_count = 0;
	int        beats_seen = 0;
	int        burst_left = 0;
	int        gap_left = 0;
	bit        offering = 1'b0;
	adc_item_t next_item;
	int        hold_left = 0;
	bit        hold_done = 1'b0;
	int        stall_mode = 0;
	int        mode_left = 0;

	multichannel_sample_averager_unit #(
		.CHANNELS(CHAN_COUNT),
		.COUNT_BITS(CNT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Print one mismatch line and count it
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR at result %0d: %s got %0d expected %0d", results_out, what, got, want);
		error_count++;
	endtask

	task automatic add_item(input logic [KIND_BITS-1:0] kind, input int channel,
			input int raw_word, input bit wait_idle = 1'b0);
		adc_item_t it;
		it.kind      = kind;
		it.channel   = channel[CHAN_BITS-1:0];
		it.raw_word  = raw_word[RAW_BITS-1:0];
		it.wait_idle = wait_idle;
		pending_items.push_back(it);
		total_items++;
	endtask

	// Update the channel sums and counts for one accepted beat; queue a result on reads
	task automatic track_channels(input logic [KIND_BITS-1:0] kind,
			input logic [CHAN_BITS-1:0] channel, input logic [RAW_BITS-1:0] raw_word);
		avg_result_t res;
		case (kind)
			KIND_SAMPLE: begin
				if (channel < CHAN_COUNT && chan_count[channel] != CNT_MAX) begin
					chan_sum[channel]   = chan_sum[channel] + SUM_BITS'(raw_word >> SAMPLE_SHIFT);
					chan_count[channel] = chan_count[channel] + 1'b1;
				end
			end
			KIND_READ: begin
				res.average   = '0;
				res.was_empty = 1'b1;
				if (channel < CHAN_COUNT) begin
					if (chan_count[channel] != 0) begin
						res.average   = SAMPLE_BITS'(chan_sum[channel] / chan_count[channel]);
						res.was_empty = 1'b0;
					end
					chan_sum[channel]   = '0;
					chan_count[channel] = '0;
				end
				avg_expected.push_back(res);
			end
			KIND_CLEAR: begin
				for (int i = 0; i < CHAN_COUNT; i++) begin
					chan_sum[i]   = '0;
					chan_count[i] = '0;
				end
			end
			default: ;
		endcase
	endtask

	// Check results and predict on accepted input beats at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (avg_expected.size() == 0) begin
					$display("ERROR: result beat with nothing expected, average %0d empty %0d",
						m_tdata[SAMPLE_BITS-1:0], m_tuser);
					error_count++;
				end else begin
					avg_result_t want;
					want = avg_expected.pop_front();
					if (m_tdata[SAMPLE_BITS-1:0] !== want.average)
						report_mismatch("average", int'(m_tdata[SAMPLE_BITS-1:0]),
							int'(want.average));
					if (m_tuser !== want.was_empty)
						report_mismatch("was_empty", int'(m_tuser), int'(want.was_empty));
				end
				results_out++;
			end
			if (s_tvalid && s_tready) begin
				track_channels(s_tuser, s_tdata[CHAN_BITS-1:0],
					s_tdata[CHAN_BITS +: RAW_BITS]);
				beats_in++;
			end
		end
	end

	// Offer items in bursts with random gaps; hold a beat until it is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (beats_seen != beats_in) begin
				beats_seen = beats_in;
				offering   = 1'b0;
			end
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_items.size() != 0 &&
						!(pending_items[0].wait_idle && avg_expected.size() != 0)) begin
					next_item = pending_items.pop_front();
					offering  = 1'b1;
					s_tdata  <= {{(S_DATA_BITS - CHAN_BITS - RAW_BITS){1'b0}},
						next_item.raw_word, next_item.channel};
					s_tuser  <= next_item.kind;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
			s_tvalid <= offering;
		end
	end

	// Stall the result side on its own pattern, with one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left  = $urandom_range(20, 200);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int chan;
		int n;
		int seg;
		int random_start;
		bit paused;

		for (int i = 0; i < CHAN_COUNT; i++) begin
			chan_sum[i]   = '0;
			chan_count[i] = '0;
		end

		// Directed: empty reads, word extremes, truncation, clear, reserved kind
		add_item(KIND_READ, 0, 0);
		add_item(KIND_SAMPLE, 7, 16'h0000);
		add_item(KIND_SAMPLE, 7, 16'hFFFF);
		add_item(KIND_SAMPLE, 7, 16'h0007);
		add_item(KIND_SAMPLE, 7, 16'h0008);
		add_item(KIND_READ, 7, 16'hFFFF);
		add_item(KIND_READ, 7, 0);
		add_item(KIND_SAMPLE, 3, 16'hFFFF);
		add_item(KIND_SAMPLE, 3, 16'h1234);
		add_item(KIND_SAMPLE, 4, 16'hAAAA);
		add_item(KIND_CLEAR, 5, 16'h5555);
		add_item(KIND_READ, 3, 0);
		add_item(KIND_READ, 4, 0);
		add_item(KIND_RESERVED, 6, 16'hFFFF);
		add_item(KIND_READ, 6, 0);
		add_item(KIND_SAMPLE, 1, 16'h0008);
		add_item(KIND_SAMPLE, 1, 16'h0010);
		add_item(KIND_READ, 1, 0);
		add_item(KIND_SAMPLE, 2, 16'h0010);
		add_item(KIND_SAMPLE, 2, 16'h0018);
		add_item(KIND_SAMPLE, 2, 16'h0020);
		add_item(KIND_READ, 2, 0);
		add_item(KIND_SAMPLE, 5, 16'h8000);
		add_item(KIND_READ, 5, 0);

		// Random: mostly sample runs closed by a read, some noise, clears and empty reads
		random_start = total_items;
		paused = 1'b0;
		while (total_items - random_start < RANDOM_ITEMS - 280) begin
			seg  = $urandom_range(0, 9);
			chan = $urandom_range(0, CHAN_COUNT - 1);
			if (!paused && total_items - random_start > 250) begin
				paused = 1'b1;
				add_item(KIND_READ, chan, $urandom, 1'b1);
			end else if (seg < 6) begin
				n = $urandom_range(1, 12);
				repeat (n) add_item(KIND_SAMPLE, chan, $urandom);
				add_item(KIND_READ, chan, $urandom);
			end else if (seg < 9) begin
				n = $urandom_range(1, 6);
				repeat (n) add_item(KIND_BITS'($urandom_range(0, 3)), $urandom, $urandom);
			end else begin
				add_item(KIND_CLEAR, chan, $urandom);
				add_item(KIND_READ, chan, $urandom);
			end
		end

		// Saturate one channel at the largest word, then push extra samples that must drop
		chan = $urandom_range(0, CHAN_COUNT - 1);
		repeat (int'(CNT_MAX)) add_item(KIND_SAMPLE, chan, 16'hFFFF);
		repeat (8) add_item(KIND_SAMPLE, chan, $urandom);
		add_item(KIND_READ, chan, $urandom);
		add_item(KIND_READ, chan, $urandom);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (beats_in == total_items);
		wait (avg_expected.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_multichannel_sample_averager_unit: PASS");
		end else begin
			$display("tb_multichannel_sample_averager_unit: FAIL");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#1000000;
		$display("tb_multichannel_sample_averager_unit: FAIL");
		$finish;
	end

endmodule
